>>> rtl/core/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// types, action codes and format markers shared by the item encoder
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = 4;

  typedef enum logic [4:0] {
    ActNil     = 5'd0,
    ActTrue    = 5'd1,
    ActFalse   = 5'd2,
    ActPosFix  = 5'd3,
    ActNegFix  = 5'd4,
    ActUint8   = 5'd5,
    ActUint16  = 5'd6,
    ActUint32  = 5'd7,
    ActUint64  = 5'd8,
    ActInt8    = 5'd9,
    ActInt16   = 5'd10,
    ActInt32   = 5'd11,
    ActInt64   = 5'd12,
    ActFloat32 = 5'd13,
    ActFloat64 = 5'd14,
    ActStr     = 5'd15,
    ActBin     = 5'd16,
    ActArray   = 5'd17,
    ActMap     = 5'd18,
    ActExt     = 5'd19,
    ActBody    = 5'd20
  } action_e;

  localparam logic [7:0] MrkNil      = 8'hc0;
  localparam logic [7:0] MrkFalse    = 8'hc2;
  localparam logic [7:0] MrkTrue     = 8'hc3;
  localparam logic [7:0] MrkBin8     = 8'hc4;
  localparam logic [7:0] MrkBin16    = 8'hc5;
  localparam logic [7:0] MrkBin32    = 8'hc6;
  localparam logic [7:0] MrkExt8     = 8'hc7;
  localparam logic [7:0] MrkExt16    = 8'hc8;
  localparam logic [7:0] MrkExt32    = 8'hc9;
  localparam logic [7:0] MrkFloat32  = 8'hca;
  localparam logic [7:0] MrkFloat64  = 8'hcb;
  localparam logic [7:0] MrkUint8    = 8'hcc;
  localparam logic [7:0] MrkUint16   = 8'hcd;
  localparam logic [7:0] MrkUint32   = 8'hce;
  localparam logic [7:0] MrkUint64   = 8'hcf;
  localparam logic [7:0] MrkInt8     = 8'hd0;
  localparam logic [7:0] MrkInt16    = 8'hd1;
  localparam logic [7:0] MrkInt32    = 8'hd2;
  localparam logic [7:0] MrkInt64    = 8'hd3;
  localparam logic [7:0] MrkFixExt1  = 8'hd4;
  localparam logic [7:0] MrkFixExt2  = 8'hd5;
  localparam logic [7:0] MrkFixExt4  = 8'hd6;
  localparam logic [7:0] MrkFixExt8  = 8'hd7;
  localparam logic [7:0] MrkFixExt16 = 8'hd8;
  localparam logic [7:0] MrkStr8     = 8'hd9;
  localparam logic [7:0] MrkStr16    = 8'hda;
  localparam logic [7:0] MrkStr32    = 8'hdb;
  localparam logic [7:0] MrkArray16  = 8'hdc;
  localparam logic [7:0] MrkArray32  = 8'hdd;
  localparam logic [7:0] MrkMap16    = 8'hde;
  localparam logic [7:0] MrkMap32    = 8'hdf;
  localparam logic [7:0] MrkFixStr   = 8'ha0;
  localparam logic [7:0] MrkFixArray = 8'h90;
  localparam logic [7:0] MrkFixMap   = 8'h80;

  typedef struct packed {
    logic [4:0]        action;
    logic [63:0]       value;
    logic signed [7:0] ext_type;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // encoded item: bytes in stream order, byte 0 first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          cnt;
  } frame_t;

endpackage

`default_nettype wire

>>> rtl/core/mie_encode.sv
// ----------------------------------------------------------------------------
// mie_encode
// combinational encoder: one typed item to a frame of up to nine bytes
// ----------------------------------------------------------------------------
`default_nettype none

module mie_encode
  import mie_pkg::*;
(
  input  in_item_t item_i,
  output frame_t   frame_o
);

  logic [7:0]      marker;
  logic [3:0]      ndata;
  logic            has_typ;
  logic            known;
  logic [31:0]     len;
  logic [7:0][7:0] val_bytes;

  assign len       = item_i.value[31:0];
  assign val_bytes = item_i.value;

  always_comb begin
    marker  = '0;
    ndata   = '0;
    has_typ = 1'b0;
    known   = 1'b1;
    unique case (item_i.action)
      ActNil:   marker = MrkNil;
      ActTrue:  marker = MrkTrue;
      ActFalse: marker = MrkFalse;
      ActPosFix, ActNegFix, ActBody: marker = item_i.value[7:0];
      ActUint8:   begin marker = MrkUint8;   ndata = 4'd1; end
      ActUint16:  begin marker = MrkUint16;  ndata = 4'd2; end
      ActUint32:  begin marker = MrkUint32;  ndata = 4'd4; end
      ActUint64:  begin marker = MrkUint64;  ndata = 4'd8; end
      ActInt8:    begin marker = MrkInt8;    ndata = 4'd1; end
      ActInt16:   begin marker = MrkInt16;   ndata = 4'd2; end
      ActInt32:   begin marker = MrkInt32;   ndata = 4'd4; end
      ActInt64:   begin marker = MrkInt64;   ndata = 4'd8; end
      ActFloat32: begin marker = MrkFloat32; ndata = 4'd4; end
      ActFloat64: begin marker = MrkFloat64; ndata = 4'd8; end
      ActStr: begin
        if (len < 32'd32) begin
          marker = MrkFixStr | {3'b000, len[4:0]};
        end else if (len < 32'd256) begin
          marker = MrkStr8;  ndata = 4'd1;
        end else if (len < 32'd65536) begin
          marker = MrkStr16; ndata = 4'd2;
        end else begin
          marker = MrkStr32; ndata = 4'd4;
        end
      end
      ActBin: begin
        if (len < 32'd256) begin
          marker = MrkBin8;  ndata = 4'd1;
        end else if (len < 32'd65536) begin
          marker = MrkBin16; ndata = 4'd2;
        end else begin
          marker = MrkBin32; ndata = 4'd4;
        end
      end
      ActArray: begin
        if (len < 32'd16) begin
          marker = MrkFixArray | {4'b0000, len[3:0]};
        end else if (len < 32'd65536) begin
          marker = MrkArray16; ndata = 4'd2;
        end else begin
          marker = MrkArray32; ndata = 4'd4;
        end
      end
      ActMap: begin
        if (len < 32'd16) begin
          marker = MrkFixMap | {4'b0000, len[3:0]};
        end else if (len < 32'd65536) begin
          marker = MrkMap16; ndata = 4'd2;
        end else begin
          marker = MrkMap32; ndata = 4'd4;
        end
      end
      ActExt: begin
        has_typ = 1'b1;
        if (len == 32'd1)       marker = MrkFixExt1;
        else if (len == 32'd2)  marker = MrkFixExt2;
        else if (len == 32'd4)  marker = MrkFixExt4;
        else if (len == 32'd8)  marker = MrkFixExt8;
        else if (len == 32'd16) marker = MrkFixExt16;
        else if (len < 32'd256) begin
          marker = MrkExt8;  ndata = 4'd1;
        end else if (len < 32'd65536) begin
          marker = MrkExt16; ndata = 4'd2;
        end else begin
          marker = MrkExt32; ndata = 4'd4;
        end
      end
      default: known = 1'b0;
    endcase
  end

  // body bytes: big-endian data, then the ext type byte, then zero fill
  always_comb begin
    logic [3:0] idx;
    frame_o.bytes    = '0;
    frame_o.bytes[0] = marker;
    for (int k = 1; k < MaxBytes; k++) begin
      idx = ndata - 4'(k);
      if (4'(k) <= ndata) begin
        frame_o.bytes[k] = val_bytes[idx[2:0]];
      end else if (has_typ && (4'(k) == ndata + 4'd1)) begin
        frame_o.bytes[k] = item_i.ext_type;
      end
    end
    frame_o.cnt = known ? (4'd1 + ndata + {3'b000, has_typ}) : '0;
  end

endmodule

`default_nettype wire

>>> rtl/core/mie_serializer.sv
// ----------------------------------------------------------------------------
// mie_serializer
// frame register, one byte per cycle unless stalled, into a registered output
// ----------------------------------------------------------------------------
`default_nettype none

module mie_serializer
  import mie_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_valid_i,
  output logic            load_ready_o,
  input  frame_t          frame_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output out_item_t       out_item_o,
  output logic [CntW-1:0] frame_cnt_o
);

  logic [MaxBytes-1:0][7:0] bytes_q, bytes_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;
  logic                     move;
  logic                     load;

  // next byte moves out when the output register is free or being drained
  assign move         = (cnt_q != '0) && (!out_valid_q || out_ready_i);
  assign load_ready_o = (cnt_q == '0) || ((cnt_q == 4'd1) && move);
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    bytes_d     = bytes_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      bytes_d = frame_i.bytes;
      cnt_d   = frame_i.cnt;
    end else if (move) begin
      bytes_d = {8'h00, bytes_q[MaxBytes-1:1]};
      cnt_d   = cnt_q - 4'd1;
    end
    if (move) begin
      out_valid_d    = 1'b1;
      out_d.out_byte = bytes_q[0];
      out_d.last     = (cnt_q == 4'd1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign frame_cnt_o = cnt_q;

endmodule

`default_nettype wire

>>> rtl/core/msgpack_item_encoder.sv
// ----------------------------------------------------------------------------
// msgpack_item_encoder
// MessagePack item encoder: one typed item in, its encoded bytes out
// ----------------------------------------------------------------------------
// usage
//   input channel  : in_valid_i / in_ready_o carry one in_item_t per transfer
//                    (action, value, ext_type); body bytes use the body action
//   output channel : out_valid_o / out_ready_i carry one encoded byte per
//                    transfer, with last set on the final byte of an item
//   first byte     : the first byte of an item is offered once the transfer
//                    has loaded the frame register and the byte has then
//                    moved on into the output register
//   throughput     : one byte per cycle while out_ready_i is high, set by the
//                    byte-wide output register; an item holds the input until
//                    its last byte moves on, so fixints, nil/bool and body bytes
//                    go one per cycle, headers and scalars have up to nine bytes
//   unknown action : an action above the body code is taken and yields nothing
//   reset          : rst_ni clears the frame count and output valid, so the
//                    block comes up empty and ready
//   receiver stall : the output byte holds; the frame behind it holds its
//                    remaining bytes, and one more item can still be taken
//                    once the frame has handed on its last byte
// ----------------------------------------------------------------------------
`default_nettype none

module msgpack_item_encoder
  import mie_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  frame_t          enc_frame;
  logic [CntW-1:0] frame_cnt;

  // combinational encode of the item at the input
  mie_encode u_encode (
    .item_i  (in_item_i),
    .frame_o (enc_frame)
  );

  // frame register and output register
  mie_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_i),
    .load_ready_o (in_ready_o),
    .frame_i      (enc_frame),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o),
    .frame_cnt_o  (frame_cnt)
  );

`ifndef NO_ASSERTIONS
  // frame never holds more bytes than the longest encoding
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_cnt <= 4'(MaxBytes))
    else $error("frame count above maximum");

  // an input transfer loads the encoded length into the frame
  a_load_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (frame_cnt == $past(enc_frame.cnt)))
    else $error("frame count does not match encoded item");

  // a byte that is not the last of its item has its successors in the frame
  a_rest_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |-> (frame_cnt != '0))
    else $error("item bytes lost before last");

  // input is only taken when the frame is empty or emptying
  a_ready_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (frame_cnt <= 4'd1))
    else $error("input ready while frame busy");
`endif

endmodule

`default_nettype wire

>>> test/mie_stream_checker.sv
// ----------------------------------------------------------------------------
// mie_stream_checker
// watches both channels of the item encoder, predicts each item's encoded
// bytes and compares them, in order, with the output transfers
// ----------------------------------------------------------------------------
module mie_stream_checker
  import mie_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  out_item_t   encoded_q [$];
  int unsigned fails;
  int unsigned checked;

  // bytes of one item: marker, big-endian payload, then the ext type byte
  function automatic void encode_item(input in_item_t item);
    logic [7:0]  marker;
    logic [63:0] payload;
    logic [63:0] shifted;
    logic [31:0] len;
    int unsigned plen;
    int unsigned total;
    int unsigned k;
    bit          emits;
    bit          with_type;
    out_item_t   b;
    len       = item.value[31:0];
    payload   = item.value;
    marker    = '0;
    plen      = 0;
    emits     = 1'b1;
    with_type = 1'b0;
    case (item.action)
      ActNil:   marker = MrkNil;
      ActTrue:  marker = MrkTrue;
      ActFalse: marker = MrkFalse;
      ActPosFix, ActNegFix, ActBody: marker = item.value[7:0];
      ActUint8:   begin marker = MrkUint8;   plen = 1; end
      ActUint16:  begin marker = MrkUint16;  plen = 2; end
      ActUint32:  begin marker = MrkUint32;  plen = 4; end
      ActUint64:  begin marker = MrkUint64;  plen = 8; end
      ActInt8:    begin marker = MrkInt8;    plen = 1; end
      ActInt16:   begin marker = MrkInt16;   plen = 2; end
      ActInt32:   begin marker = MrkInt32;   plen = 4; end
      ActInt64:   begin marker = MrkInt64;   plen = 8; end
      ActFloat32: begin marker = MrkFloat32; plen = 4; end
      ActFloat64: begin marker = MrkFloat64; plen = 8; end
      ActStr: begin
        payload = {32'h0, len};
        if (len < 32) marker = MrkFixStr | len[7:0];
        else if (len < 256) begin marker = MrkStr8; plen = 1; end
        else if (len < 65536) begin marker = MrkStr16; plen = 2; end
        else begin marker = MrkStr32; plen = 4; end
      end
      ActBin: begin
        payload = {32'h0, len};
        if (len < 256) begin marker = MrkBin8; plen = 1; end
        else if (len < 65536) begin marker = MrkBin16; plen = 2; end
        else begin marker = MrkBin32; plen = 4; end
      end
      ActArray: begin
        payload = {32'h0, len};
        if (len < 16) marker = MrkFixArray | len[7:0];
        else if (len < 65536) begin marker = MrkArray16; plen = 2; end
        else begin marker = MrkArray32; plen = 4; end
      end
      ActMap: begin
        payload = {32'h0, len};
        if (len < 16) marker = MrkFixMap | len[7:0];
        else if (len < 65536) begin marker = MrkMap16; plen = 2; end
        else begin marker = MrkMap32; plen = 4; end
      end
      ActExt: begin
        payload   = {32'h0, len};
        with_type = 1'b1;
        case (len)
          32'd1:  marker = MrkFixExt1;
          32'd2:  marker = MrkFixExt2;
          32'd4:  marker = MrkFixExt4;
          32'd8:  marker = MrkFixExt8;
          32'd16: marker = MrkFixExt16;
          default: begin
            if (len < 256) begin marker = MrkExt8; plen = 1; end
            else if (len < 65536) begin marker = MrkExt16; plen = 2; end
            else begin marker = MrkExt32; plen = 4; end
          end
        endcase
      end
      default: emits = 1'b0;
    endcase
    total = emits ? 1 + plen + with_type : 0;
    for (k = 0; k < total; k++) begin
      if (k == 0) begin
        b.out_byte = marker;
      end else if (k <= plen) begin
        shifted    = payload >> (8 * (plen - k));
        b.out_byte = shifted[7:0];
      end else begin
        b.out_byte = item.ext_type;
      end
      b.last = (k == total - 1);
      encoded_q.push_back(b);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      encoded_q.delete();
      fails      = 0;
      checked    = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
      checked_o  <= 0;
    end else begin
      if (in_valid_i && in_ready_i) encode_item(in_item_i);
      if (out_valid_i && out_ready_i) begin
        if (encoded_q.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %02h last %0b",
                   $time, out_item_i.out_byte, out_item_i.last);
          fails++;
        end else begin
          want = encoded_q.pop_front();
          checked++;
          if (out_item_i.out_byte !== want.out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h",
                     $time, want.out_byte, out_item_i.out_byte);
            fails++;
          end
          if (out_item_i.last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b",
                     $time, want.last, out_item_i.last);
            fails++;
          end
        end
      end
      fail_cnt_o <= fails;
      pending_o  <= encoded_q.size();
      checked_o  <= checked;
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the messagepack item encoder
// ----------------------------------------------------------------------------
// a directed pass hits every action, the scalar extremes, the header size
// boundaries, long lengths with upper bits set and an undefined action; then
// random headers followed by their body bytes make up most of the traffic,
// mixed with scalars, stray body bytes and cut-short bodies. both channels
// idle at random, with quiet stretches where they do not. the checker
// predicts and compares every byte; this module only drives and judges.
// ----------------------------------------------------------------------------
module tb_top
  import mie_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems   = 420;
  localparam int unsigned DrainCycles   = 20;
  localparam int unsigned WatchdogLimit = 2000;
  // actions past the body code are accepted and yield nothing
  localparam logic [4:0]  ActUndefLo    = ActBody + 5'd1;
  localparam logic [4:0]  ActUndefHi    = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_item_o;

  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent;
  int unsigned undef_sent;
  int unsigned idle_cycles;
  bit          no_idle;

  msgpack_item_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  mie_stream_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_i  (out_item_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // idle length: mostly none or short, now and then long; nothing at all
  // during a quiet stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (no_idle) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // header lengths: mostly small so that bodies stay short, with the
  // size-class boundaries and the odd huge value
  function automatic logic [31:0] pick_len();
    logic [31:0] bounds [15];
    int unsigned r;
    bounds = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd15, 32'd16,
               32'd31, 32'd32, 32'd255, 32'd256, 32'd65535, 32'd65536,
               32'hffff_ffff};
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(0, 20);
    if (r < 80) return bounds[$urandom_range(14)];
    if (r < 92) return $urandom_range(0, 70000);
    return $urandom;
  endfunction

  // one input transfer; valid is only dropped when a gap comes before it
  task automatic send_item(input logic [4:0] act, input logic [63:0] val,
                           input logic signed [7:0] typ);
    int unsigned gap;
    in_item_t    item;
    gap           = pick_gap();
    item.action   = act;
    item.value    = val;
    item.ext_type = typ;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (act <= ActBody) items_sent++;
    else undef_sent++;
  endtask

  // one random group: a header with its body, a lone item, or noise
  task automatic send_random_group();
    int unsigned r;
    int unsigned nbody;
    int unsigned i;
    logic [63:0] val;
    logic [31:0] len;
    logic [4:0]  kind;
    r   = $urandom_range(99);
    val = {$urandom, $urandom};
    if ($urandom_range(29) == 0) no_idle <= ~no_idle;
    if (r < 4) begin
      send_item(5'($urandom_range(ActUndefLo, ActUndefHi)), val, 8'($urandom));
    end else if (r < 55) begin
      // str, bin or ext: header then len body bytes when len is at most 24,
      // occasionally cut short; longer headers get at most three body bytes
      case ($urandom_range(2))
        0:       kind = ActStr;
        1:       kind = ActBin;
        default: kind = ActExt;
      endcase
      len = pick_len();
      val = {($urandom_range(7) == 0) ? $urandom : 32'h0, len};
      send_item(kind, val, 8'($urandom));
      if (len <= 24) nbody = ($urandom_range(9) == 0) ? $urandom_range(len) : len;
      else nbody = $urandom_range(3);
      for (i = 0; i < nbody; i++) send_item(ActBody, {$urandom, $urandom}, 8'($urandom));
    end else begin
      kind = 5'($urandom_range(ActNil, ActBody));
      case ($urandom_range(9))
        0:       val = '0;
        1:       val = '1;
        default: ;
      endcase
      if (kind == ActArray || kind == ActMap)
        val = {($urandom_range(3) == 0) ? $urandom : 32'h0, pick_len()};
      send_item(kind, val, 8'($urandom));
    end
  endtask

  // receiver: random stalls on the output, single-cycle to long
  initial begin
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // watchdog: cycles in a row with no transfer on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transfer for %0d cycles, %0d bytes outstanding",
               $time, idle_cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    idle_cycles = 0;
    items_sent  = 0;
    undef_sent  = 0;
    no_idle     = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every action, scalar extremes, size boundaries
    send_item(ActNil,     64'h0, 8'sd0);
    send_item(ActTrue,    '1,    8'sd0);
    send_item(ActFalse,   '0,    8'sd0);
    send_item(ActPosFix,  64'hffff_ffff_ffff_ff7f, -8'sd128);
    send_item(ActNegFix,  64'h0000_0000_0000_00e0, 8'sd127);
    send_item(ActUint8,   64'hffff_ffff_ffff_ffff, 8'sd0);
    send_item(ActUint16,  64'h1234_5678_9abc_def0, 8'sd0);
    send_item(ActUint32,  64'h0000_0000_8000_0001, 8'sd0);
    // uint64 uses the 64-bit marker
    send_item(ActUint64,  64'hffff_ffff_ffff_ffff, 8'sd0);
    send_item(ActInt8,    64'h0000_0000_0000_0080, 8'sd0);
    send_item(ActInt16,   64'hffff_ffff_ffff_8000, 8'sd0);
    send_item(ActInt32,   64'h0000_0000_7fff_ffff, 8'sd0);
    send_item(ActInt64,   64'h8000_0000_0000_0000, 8'sd0);
    send_item(ActFloat32, 64'h0000_0000_3f80_0000, 8'sd0);
    send_item(ActFloat64, 64'h7ff8_0000_0000_0001, 8'sd0);
    send_item(ActStr,     64'd31,    8'sd0);
    send_item(ActStr,     64'd32,    8'sd0);
    // long length: only the low 32 bits count, so this is an empty fixstr
    send_item(ActStr,     64'h1_0000_0000, 8'sd0);
    send_item(ActBin,     64'd65536, 8'sd0);
    send_item(ActArray,   64'd16,    8'sd0);
    send_item(ActMap,     64'd15,    8'sd0);
    send_item(ActExt,     64'd16,    -8'sd128);
    send_item(ActExt,     64'hffff_ffff_0000_0003, 8'sd127);
    send_item(ActBody,    64'hffff_ffff_ffff_ffff, 8'sd0);
    send_item(ActUndefHi, '1,        -8'sd1);

    while (items_sent < RandomItems) send_random_group();
    in_valid_i <= 1'b0;

    // let the last transfer reach the checker, then drain
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d items and %0d undefined actions, %0d encoded bytes checked",
             items_sent, undef_sent, checked);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
